// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

    // Field widths
    localparam int NUMERAL_W = 30;
    localparam int SBASE_W   = 4;
    localparam int TBASE_W   = 5;
    localparam int DIGIT_W   = 5;

    // Default digit store depth
    localparam int STACK_DEPTH_DEF = 32;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // floor(n / 10) = (n * DIV10_MAGIC) >> 35, exact for n < 2^32
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // Smallest target base that is converted as given
    localparam logic [TBASE_W-1:0] TBASE_MIN = TBASE_W'(2);

    // Reciprocals floor(2^32 / b); codes below two use the entry for two
    localparam logic [32:0] POW32 = 33'h1_0000_0000;
    localparam logic [31:0] RECIP_TBL [32] = '{
        32'(POW32 / 33'd2),  32'(POW32 / 33'd2),  32'(POW32 / 33'd2),  32'(POW32 / 33'd3),
        32'(POW32 / 33'd4),  32'(POW32 / 33'd5),  32'(POW32 / 33'd6),  32'(POW32 / 33'd7),
        32'(POW32 / 33'd8),  32'(POW32 / 33'd9),  32'(POW32 / 33'd10), 32'(POW32 / 33'd11),
        32'(POW32 / 33'd12), 32'(POW32 / 33'd13), 32'(POW32 / 33'd14), 32'(POW32 / 33'd15),
        32'(POW32 / 33'd16), 32'(POW32 / 33'd17), 32'(POW32 / 33'd18), 32'(POW32 / 33'd19),
        32'(POW32 / 33'd20), 32'(POW32 / 33'd21), 32'(POW32 / 33'd22), 32'(POW32 / 33'd23),
        32'(POW32 / 33'd24), 32'(POW32 / 33'd25), 32'(POW32 / 33'd26), 32'(POW32 / 33'd27),
        32'(POW32 / 33'd28), 32'(POW32 / 33'd29), 32'(POW32 / 33'd30), 32'(POW32 / 33'd31)
    };

    // Channel payloads
    typedef struct packed {
        logic [NUMERAL_W-1:0] numeral;
        logic [SBASE_W-1:0]   source_base;
        logic [TBASE_W-1:0]   target_base;
    } item_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last_digit;
    } digit_beat_t;

    // Job handed from front to back
    typedef struct packed {
        logic [NUMERAL_W-1:0] value;
        logic [TBASE_W-1:0]   tbase;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_ACC,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_FIX,
        B_RD,
        B_LOAD
    } back_state_t;

endpackage

// ===== rtl/rdc_stream_if.sv =====
interface rdc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/radix_digit_converter_top.sv =====
// Channel   Role    Payload                                  Beat when
// items     sink    numeral[29:0] source_base[3:0]           valid && ready
//                   target_base[4:0]
// digits    source  digit[4:0] last_digit                    valid && ready
//
// Front: per decimal digit, a divide step (one multiply) and an accumulate step (two).
// Back: per target digit, a multiply and a fix step to divide, a read and a load to pop;
// a run of up to 30 digits is paced by the divide loop and the store's single read port.
// A two-entry job queue lets the front evaluate the next items while the back runs.
// Reset is asynchronous, active low; the digit store needs no clearing pass.
// A stall on digits holds the back at its next pop; items stalls once the queue is full.
module radix_digit_converter_top #(
    parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rdc_stream_if.sink   items,
    rdc_stream_if.source digits
);
    logic          push_valid, push_ready;
    logic          pop_valid, pop_ready;
    rdc_pkg::job_t push_job, pop_job;

    rdc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    rdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    rdc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .digits    (digits)
    );
endmodule

// ===== rtl/rdc_ram.sv =====
module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/rdc_front.sv =====
module rdc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    rdc_stream_if.sink           items,
    output logic                 job_valid,
    input  logic                 job_ready,
    output rdc_pkg::job_t        job
);
    localparam int NW = rdc_pkg::NUMERAL_W;

    rdc_pkg::front_state_t state_reg, state_next;

    logic [NW-1:0]                  n_reg, n_next;
    logic [NW-1:0]                  q_reg, q_next;
    logic [NW-1:0]                  acc_reg, acc_next;
    logic [NW-1:0]                  weight_reg, weight_next;
    logic [rdc_pkg::SBASE_W-1:0]    sbase_reg, sbase_next;
    logic [rdc_pkg::TBASE_W-1:0]    tbase_reg, tbase_next;

    logic [61:0]                    div_prod;
    logic [NW-1:0]                  q_times10;
    logic [3:0]                     dec_digit;
    logic [NW+3:0]                  term;
    logic [NW+3:0]                  weight_prod;

    // Decimal digit extraction and power-weighted terms
    always_comb
    begin
        div_prod    = 62'(n_reg) * 62'(rdc_pkg::DIV10_MAGIC);
        q_times10   = (q_reg << 3) + (q_reg << 1);
        dec_digit   = 4'(n_reg - q_times10);
        term        = (NW+4)'(dec_digit) * (NW+4)'(weight_reg);
        weight_prod = (NW+4)'(weight_reg) * (NW+4)'(sbase_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdc_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        q_reg      <= q_next;
        acc_reg    <= acc_next;
        weight_reg <= weight_next;
        sbase_reg  <= sbase_next;
        tbase_reg  <= tbase_next;
    end

    // Evaluation sequencer: a divide step and an accumulate step per decimal digit
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        q_next      = q_reg;
        acc_next    = acc_reg;
        weight_next = weight_reg;
        sbase_next  = sbase_reg;
        tbase_next  = tbase_reg;
        items.ready = 1'b0;
        job_valid   = 1'b0;
        job.value   = acc_reg;
        job.tbase   = tbase_reg;

        case (state_reg)
            rdc_pkg::F_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                begin
                    n_next      = items.data.numeral;
                    sbase_next  = items.data.source_base;
                    // bases zero and one fold to two
                    tbase_next  = (items.data.target_base < rdc_pkg::TBASE_MIN) ?
                                  rdc_pkg::TBASE_MIN : items.data.target_base;
                    acc_next    = '0;
                    weight_next = NW'(1);
                    state_next  = rdc_pkg::F_DIV;
                end
            end
            rdc_pkg::F_DIV:
            begin
                if (n_reg == '0)
                begin
                    state_next = rdc_pkg::F_PUSH;
                end
                else
                begin
                    q_next     = NW'(div_prod >> rdc_pkg::DIV10_SHIFT);
                    state_next = rdc_pkg::F_ACC;
                end
            end
            rdc_pkg::F_ACC:
            begin
                acc_next    = acc_reg + term[NW-1:0];
                weight_next = weight_prod[NW-1:0];
                n_next      = q_reg;
                state_next  = rdc_pkg::F_DIV;
            end
            rdc_pkg::F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = rdc_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = rdc_pkg::F_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/rdc_queue.sv =====
module rdc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rdc_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rdc_pkg::job_t pop_job
);
    localparam int AW = rdc_pkg::QUEUE_AW;

    rdc_pkg::job_t entries_reg [rdc_pkg::QUEUE_DEPTH];
    logic [AW:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW:0]   rd_ptr_reg, rd_ptr_next;
    logic          empty, full, do_push, do_pop;

    // Pointers carry a wrap bit to tell full from empty
    always_comb
    begin
        empty       = (wr_ptr_reg == rd_ptr_reg);
        full        = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                      (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
        push_ready  = !full;
        pop_valid   = !empty;
        do_push     = push_valid && !full;
        do_pop      = pop_ready && !empty;
        wr_ptr_next = wr_ptr_reg + (AW+1)'(do_push);
        rd_ptr_next = rd_ptr_reg + (AW+1)'(do_pop);
        pop_job     = entries_reg[rd_ptr_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg[AW-1:0]] <= push_job;
        end
    end
endmodule

// ===== rtl/rdc_back.sv =====
module rdc_back #(
    parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  rdc_pkg::job_t job,
    rdc_stream_if.source  digits
);
    localparam int NW = rdc_pkg::NUMERAL_W;
    localparam int BW = rdc_pkg::TBASE_W;
    localparam int DW = rdc_pkg::DIGIT_W;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    rdc_pkg::back_state_t state_reg, state_next;

    logic [NW-1:0]       r_reg, r_next;
    logic [NW-1:0]       qest_reg, qest_next;
    logic [BW-1:0]       b_reg, b_next;
    logic [TW-1:0]       top_reg, top_next;
    logic                out_valid_reg, out_valid_next;
    rdc_pkg::digit_beat_t out_data_reg, out_data_next;

    logic [61:0]         recip_prod;
    logic [NW+BW-1:0]    qb_prod;
    logic [NW-1:0]       rem_est;
    logic                rem_over;
    logic [NW-1:0]       rem_fix;
    logic [NW-1:0]       q_fix;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DW-1:0]       wr_data;
    logic [AW-1:0]       rd_addr;
    logic [DW-1:0]       rd_data;
    logic [TW-1:0]       top_dec;

    // Digit store
    rdc_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Division by the target base: reciprocal estimate, then one correction
    always_comb
    begin
        recip_prod = 62'(r_reg) * 62'(rdc_pkg::RECIP_TBL[b_reg]);
        qb_prod    = (NW+BW)'(qest_reg) * (NW+BW)'(b_reg);
        rem_est    = r_reg - qb_prod[NW-1:0];
        rem_over   = (rem_est >= NW'(b_reg));
        rem_fix    = rem_over ? (rem_est - NW'(b_reg)) : rem_est;
        q_fix      = rem_over ? (qest_reg + NW'(1)) : qest_reg;
        top_dec    = top_reg - TW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::B_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        qest_reg     <= qest_next;
        b_reg        <= b_next;
        out_data_reg <= out_data_next;
    end

    assign digits.valid = out_valid_reg;
    assign digits.data  = out_data_reg;

    // Divide and push, then pop most significant first
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        qest_next      = qest_reg;
        b_next         = b_reg;
        top_next       = top_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !digits.ready;
        job_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = top_reg[AW-1:0];
        wr_data        = rem_fix[DW-1:0];
        rd_addr        = top_reg[AW-1:0];

        case (state_reg)
            rdc_pkg::B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    r_next   = job.value;
                    b_next   = job.tbase;
                    top_next = '0;
                    // a zero value yields no digits
                    if (job.value != '0)
                    begin
                        state_next = rdc_pkg::B_MUL;
                    end
                end
            end
            rdc_pkg::B_MUL:
            begin
                qest_next  = recip_prod[61:32];
                state_next = rdc_pkg::B_FIX;
            end
            rdc_pkg::B_FIX:
            begin
                // a full store drops the digit
                if (top_reg < TW'(STACK_DEPTH))
                begin
                    wr_en    = 1'b1;
                    top_next = top_reg + TW'(1);
                end
                r_next     = q_fix;
                state_next = (q_fix == '0) ? rdc_pkg::B_RD : rdc_pkg::B_MUL;
            end
            rdc_pkg::B_RD:
            begin
                rd_addr    = top_dec[AW-1:0];
                top_next   = top_dec;
                state_next = rdc_pkg::B_LOAD;
            end
            rdc_pkg::B_LOAD:
            begin
                if (!out_valid_reg || digits.ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.digit      = rd_data;
                    out_data_next.last_digit = (top_reg == '0);
                    state_next = (top_reg == '0) ? rdc_pkg::B_IDLE : rdc_pkg::B_RD;
                end
            end
            default:
            begin
                state_next = rdc_pkg::B_IDLE;
            end
        endcase
    end
endmodule

// ===== tb/radix_digit_converter_top_test.sv =====
`timescale 1ns / 100ps

module radix_digit_converter_top_test;

    localparam int          DECIMAL_RADIX = 10;
    localparam logic [63:0] VALUE_MASK    = 64'h3FFF_FFFF;
    localparam logic [29:0] NUMERAL_MAX   = 30'h3FFF_FFFF;
    localparam int          RANDOM_ITEMS  = 410;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          SETTLE_CYCLES = 160;

    // One item waiting to go out, with its lead-in gap
    typedef struct {
        rdc_pkg::item_t beat;
        int             gap;
        bit             hold;
    } pending_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Local copies of the driven signals so they are known from time zero
    logic           item_valid  = 1'b0;
    rdc_pkg::item_t item_data   = '0;
    logic           digit_ready = 1'b0;

    pending_t             pending_items [$];
    rdc_pkg::digit_beat_t expected_digits [$];

    int                   err_count  = 0;
    int                   idle_count = 0;
    int                   stall_left = 0;
    int                   calm_left  = 0;
    bit                   presenting;
    pending_t             next_item;
    rdc_pkg::digit_beat_t want;

    rdc_stream_if #(.payload_t(rdc_pkg::item_t))       items_if ();
    rdc_stream_if #(.payload_t(rdc_pkg::digit_beat_t)) digits_if ();

    assign items_if.valid  = item_valid;
    assign items_if.data   = item_data;
    assign digits_if.ready = digit_ready;

    radix_digit_converter_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items_if),
        .digits (digits_if)
    );

    // Clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Evaluate the numeral in its source base, then split it into target-base digits
    function automatic void predict_digits(rdc_pkg::item_t it);
        logic [63:0]          acc;
        logic [63:0]          weight;
        logic [29:0]          rest;
        logic [29:0]          value;
        logic [4:0]           tbase;
        logic [4:0]           run [$];
        rdc_pkg::digit_beat_t beat;
        acc    = '0;
        weight = 64'd1;
        rest   = it.numeral;
        while (rest != 0)
        begin
            acc    = (acc + 64'(rest % DECIMAL_RADIX) * weight) & VALUE_MASK;
            weight = (weight * 64'(it.source_base)) & VALUE_MASK;
            rest   = 30'(rest / DECIMAL_RADIX);
        end
        value = acc[29:0];
        // target codes below two act as base two
        tbase = (it.target_base < rdc_pkg::TBASE_MIN) ? rdc_pkg::TBASE_MIN : it.target_base;
        while (value != 0)
        begin
            run.push_front(5'(value % 30'(tbase)));
            value = value / 30'(tbase);
        end
        foreach (run[k])
        begin
            beat.digit      = run[k];
            beat.last_digit = (k == run.size() - 1);
            expected_digits.push_back(beat);
        end
    endfunction

    function automatic void queue_item(logic [29:0] numeral, int sbase, int tbase,
                                       int gap, bit hold);
        pending_t p;
        p.beat.numeral     = numeral;
        p.beat.source_base = 4'(sbase);
        p.beat.target_base = 5'(tbase);
        p.gap              = gap;
        p.hold             = hold;
        pending_items.push_back(p);
    endfunction

    // Numeral whose decimal digits are all valid in the given base
    function automatic logic [29:0] digits_in_base(int sbase);
        int          ndig;
        logic [29:0] n;
        ndig = $urandom_range(1, 9);
        n    = '0;
        for (int k = 0; k < ndig; k++)
        begin
            if (k == 0)
                n = 30'($urandom_range(1, sbase - 1));
            else
                n = 30'(n * DECIMAL_RADIX) + 30'($urandom_range(0, sbase - 1));
        end
        return n;
    endfunction

    // Item driver: presents pending items after their gap; held items wait until no digits are expected
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item_data  <= '0;
        end
        else
        begin
            if (item_valid && items_if.ready)
            begin
                predict_digits(item_data);
                presenting = 1'b0;
            end
            else
                presenting = item_valid;
            if (!presenting && pending_items.size() > 0)
            begin
                if (pending_items[0].gap > 0)
                    pending_items[0].gap = pending_items[0].gap - 1;
                else if (!pending_items[0].hold || expected_digits.size() == 0)
                begin
                    next_item = pending_items.pop_front();
                    item_data <= next_item.beat;
                    presenting = 1'b1;
                end
            end
            item_valid <= presenting;
        end
    end

    // Digit monitor: checks each beat against the oldest expectation, stalls at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_ready <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            if (digits_if.valid && digit_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    $error("digit: no beat expected, actual %0d last_digit %0d",
                           digits_if.data.digit, digits_if.data.last_digit);
                    err_count++;
                end
                else
                begin
                    want = expected_digits.pop_front();
                    if (digits_if.data.digit !== want.digit)
                    begin
                        $error("digit: expected %0d, actual %0d",
                               want.digit, digits_if.data.digit);
                        err_count++;
                    end
                    if (digits_if.data.last_digit !== want.last_digit)
                    begin
                        $error("last_digit: expected %0d, actual %0d",
                               want.last_digit, digits_if.data.last_digit);
                        err_count++;
                    end
                end
                // stretches with no stall now and then
                if (calm_left > 0)
                begin
                    calm_left--;
                    stall_left = 0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    calm_left  = $urandom_range(10, 40);
                    stall_left = 0;
                end
                else
                    stall_left = $urandom_range(0, 6);
            end
            else if (stall_left > 0)
                stall_left--;
            digit_ready <= (stall_left == 0);
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && items_if.ready) || (digits_if.valid && digit_ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        bit          calm;
        bit          hold;
        int          sbase;
        int          tbase;
        int          gap;
        logic [29:0] numeral;

        // directed: extremes and special cases
        queue_item(30'd0,         10, 10, 0, 0);  // zero, no beat
        queue_item(30'd1,          2,  2, 0, 0);  // single digit
        queue_item(30'd999999999, 10,  2, 0, 0);  // thirty binary digits
        queue_item(NUMERAL_MAX,   10,  2, 1, 0);  // all-ones numeral field
        queue_item(30'd111111111,  2, 20, 0, 0);
        queue_item(30'd999999999,  9, 19, 2, 0);  // digit equal to base
        queue_item(30'd987654321,  2, 10, 0, 0);  // digits above base
        queue_item(30'd123456789,  1,  2, 0, 0);  // base one: digit sum
        queue_item(30'd123456789,  0,  3, 3, 0);  // base zero: lowest digit
        queue_item(30'd123456780,  0,  3, 0, 0);  // base zero, lowest digit zero
        queue_item(30'd999999999, 15,  7, 0, 0);  // wraps to 30 bits
        queue_item(30'd777777777, 11, 16, 6, 0);
        queue_item(30'd543210,    12, 13, 0, 0);
        queue_item(30'd900000000, 13, 31, 0, 0);  // widest target code
        queue_item(30'd888888888, 14, 21, 0, 1);
        queue_item(NUMERAL_MAX,   15,  2, 0, 0);
        queue_item(30'd12345,     10,  0, 0, 0);  // target code zero
        queue_item(30'd12345,     10,  1, 4, 0);  // target code one
        queue_item(30'd1000000000, 10, 20, 0, 0); // ten decimal digits
        queue_item(30'd19,        10, 20, 0, 0);  // largest digit in base 20
        queue_item(30'd20,        10, 20, 0, 0);
        queue_item(30'd10,         2,  2, 0, 0);
        queue_item(30'd100000000, 10, 17, 5, 0);

        // random: mostly well-formed numerals, some raw field noise
        calm = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            hold = (i % 90 == 0);
            if ($urandom_range(0, 99) < 15)
            begin
                numeral = 30'($urandom_range(0, 32'(NUMERAL_MAX)));
                sbase   = $urandom_range(0, 15);
                tbase   = $urandom_range(0, 31);
            end
            else
            begin
                sbase   = $urandom_range(2, 10);
                tbase   = $urandom_range(2, 20);
                numeral = digits_in_base(sbase);
            end
            gap = calm ? 0 : $urandom_range(0, 6);
            queue_item(numeral, sbase, tbase, gap, hold);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
